// ===== src/chip8_pkg.sv =====
// chip8_pkg: shared types, codes, constants, font table and bcd helper
// for the chip8 instruction core; depends on nothing
`default_nettype none
package chip8_pkg;

    localparam int MEMORY_BYTES       = 4096;
    localparam int SCREEN_WIDTH       = 64;
    localparam int SCREEN_HEIGHT      = 32;
    localparam int STACK_DEPTH        = 16;
    localparam int FONT_BASE_DEFAULT  = 0;
    localparam int FONT_BYTES         = 80;
    localparam int PIXELS             = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int MEM_AW             = $clog2(MEMORY_BYTES);
    localparam int PIX_AW             = $clog2(PIXELS);
    localparam int SP_W               = $clog2(STACK_DEPTH);
    localparam logic [15:0] RESET_PC  = 16'd512;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_EXEC  = 2'd1;
    localparam logic [1:0] MODE_PIXEL = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_PC_RANGE  = 2'd1;
    localparam logic [1:0] ERR_UNDEFINED = 2'd2;

    localparam logic [3:0] OPC_SYS  = 4'h0;
    localparam logic [3:0] OPC_JP   = 4'h1;
    localparam logic [3:0] OPC_CALL = 4'h2;
    localparam logic [3:0] OPC_SEI  = 4'h3;
    localparam logic [3:0] OPC_SNEI = 4'h4;
    localparam logic [3:0] OPC_SER  = 4'h5;
    localparam logic [3:0] OPC_LDI  = 4'h6;
    localparam logic [3:0] OPC_ADDI = 4'h7;
    localparam logic [3:0] OPC_ALU  = 4'h8;
    localparam logic [3:0] OPC_SNER = 4'h9;
    localparam logic [3:0] OPC_SETI = 4'hA;
    localparam logic [3:0] OPC_JPV0 = 4'hB;
    localparam logic [3:0] OPC_RND  = 4'hC;
    localparam logic [3:0] OPC_DRW  = 4'hD;
    localparam logic [3:0] OPC_KEY  = 4'hE;
    localparam logic [3:0] OPC_MISC = 4'hF;

    localparam logic [15:0] WORD_CLS = 16'h00E0;
    localparam logic [15:0] WORD_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KK_SKP   = 8'h9E;
    localparam logic [7:0] KK_SKNP  = 8'hA1;
    localparam logic [7:0] KK_GETDT = 8'h07;
    localparam logic [7:0] KK_WAITK = 8'h0A;
    localparam logic [7:0] KK_SETDT = 8'h15;
    localparam logic [7:0] KK_SETST = 8'h18;
    localparam logic [7:0] KK_ADDI  = 8'h1E;
    localparam logic [7:0] KK_FONT  = 8'h29;
    localparam logic [7:0] KK_BCD   = 8'h33;
    localparam logic [7:0] KK_STORE = 8'h55;
    localparam logic [7:0] KK_LOAD  = 8'h65;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] address;
        logic [7:0]  load_byte;
        logic [15:0] keys_down;
        logic [7:0]  random_byte;
    } request_t;

    typedef struct packed {
        logic [15:0] fetched_instruction;
        logic [15:0] next_pc;
        logic [1:0]  error_code;
        logic        pixel_value;
        logic        display_changed;
        logic        sound_active;
    } result_t;

    localparam logic [7:0] HEX_FONT [FONT_BYTES] = '{
        8'hf0, 8'h90, 8'h90, 8'h90, 8'hf0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hf0, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h10, 8'hf0, 8'h10, 8'hf0,
        8'h90, 8'h90, 8'hf0, 8'h10, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'h10, 8'hf0,
        8'hf0, 8'h80, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hf0, 8'h90, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h90, 8'hf0, 8'h10, 8'hf0,
        8'hf0, 8'h90, 8'hf0, 8'h90, 8'h90, 8'he0, 8'h90, 8'he0, 8'h90, 8'he0,
        8'hf0, 8'h80, 8'h80, 8'h80, 8'hf0, 8'he0, 8'h90, 8'h90, 8'h90, 8'he0,
        8'hf0, 8'h80, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h80, 8'hf0, 8'h80, 8'h80
    };

    // hundreds, tens, ones of an 8-bit value
    function automatic logic [11:0] bcd_digits(input logic [7:0] v);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [15:0] prod;
        logic [3:0]  t;
        logic [7:0]  o;
        h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r    = v - 8'(h * 8'd100);
        prod = 16'(r) * 16'd205;
        t    = prod[14:11];
        o    = r - 8'(t * 8'd10);
        return {2'b00, h, t, o[3:0]};
    endfunction

endpackage
`default_nettype wire

// ===== src/chip8_instruction_core.sv =====
// chip8_instruction_core: chip8 interpreter core, one ram load, cycle or pixel read per transaction
// depends on chip8_pkg and chip8_ram
//
//   channel   ports                      handshake
//   request   start, busy, request       accepted when start and not busy
//   result    done, result               valid for one cycle, no stall
//   config    cfg_we, cfg_data           written when cfg_we is high
//
// a load or unused mode goes straight to the end state, a pixel read reads the screen first;
// an instruction is fetched, reads vx and vy, executes, then writes vf if flagged; a sprite
// draw rewrites one pixel per set sprite bit, 00e0 clears the screen, fx33 writes three digits
// fx55/fx65 copy one register at a time; one sequencer serves all memories, one adder serves I
// after reset the block is busy while ram, screen and registers are cleared
// results cannot be stalled; config must be written while idle, the block does not enforce this
`default_nettype none
module chip8_instruction_core #(
    parameter int FONT_BASE = chip8_pkg::FONT_BASE_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire chip8_pkg::request_t  request,
    output logic                      done,
    output chip8_pkg::result_t        result,
    input  wire logic                 cfg_we,
    input  wire logic [11:0]          cfg_data
);
    import chip8_pkg::*;

    localparam logic [MEM_AW-1:0] FONT_LO = MEM_AW'(FONT_BASE);
    localparam logic [MEM_AW-1:0] FONT_HI = MEM_AW'(FONT_BASE + FONT_BYTES);

    typedef enum logic [20:0] {
        S_CLEAR  = 21'h000001,
        S_IDLE   = 21'h000002,
        S_PIX    = 21'h000004,
        S_FETCH1 = 21'h000008,
        S_FETCH2 = 21'h000010,
        S_RDX    = 21'h000020,
        S_RDY    = 21'h000040,
        S_EXEC   = 21'h000080,
        S_WVF    = 21'h000100,
        S_CLS    = 21'h000200,
        S_DROW   = 21'h000400,
        S_DBYTE  = 21'h000800,
        S_DPIX   = 21'h001000,
        S_DRMW   = 21'h002000,
        S_DFLAG  = 21'h004000,
        S_BCD    = 21'h008000,
        S_STR_RD = 21'h010000,
        S_STR_WR = 21'h020000,
        S_LD_RD  = 21'h040000,
        S_LD_WR  = 21'h080000,
        S_END    = 21'h100000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] pc_reg, pc_next;
    logic [15:0] i_reg, i_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [7:0]  dt_reg, dt_next;
    logic [7:0]  st_reg, st_next;
    logic        wait_reg, wait_next;
    logic [15:0] prev_reg, prev_next;
    logic [15:0] stack_reg [STACK_DEPTH];
    logic        stack_we;
    logic [SP_W-1:0] stack_idx;

    request_t    req_reg, req_next;
    logic [7:0]  hi_reg, hi_next;
    logic [15:0] word_reg, word_next;
    logic [15:0] npc_reg, npc_next;
    logic [1:0]  err_reg, err_next;
    logic        pix_reg, pix_next;
    logic        drew_reg, drew_next;
    logic        tick_reg, tick_next;
    logic [7:0]  vx_reg, vx_next;
    logic [7:0]  vy_reg, vy_next;
    logic        flag_reg, flag_next;
    logic        coll_reg, coll_next;
    logic [7:0]  sprite_reg, sprite_next;
    logic [3:0]  idx_reg, idx_next;
    logic [2:0]  col_reg, col_next;
    logic [MEM_AW-1:0] cnt_reg, cnt_next;
    logic        done_reg, done_next;
    result_t     result_reg, result_next;

    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic              scr_we;
    logic [PIX_AW-1:0] scr_addr;
    logic              scr_wdata, scr_rdata;
    logic              v_we;
    logic [3:0]        v_addr;
    logic [7:0]        v_wdata, v_rdata;

    logic [MEM_AW-1:0] i_addr;
    logic [3:0]  op_x, op_y, op_n;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn;
    logic [8:0]  sum9;
    logic [7:0]  alu_r;
    logic        alu_f;
    logic        alu_flagged;
    logic        alu_ok;
    logic [11:0] bcd;
    logic [15:0] released;
    logic        key_found;
    logic [3:0]  key_num;
    logic [4:0]  draw_line;
    logic [5:0]  draw_col;
    logic        pix_advance;
    logic [MEM_AW-1:0] font_off;
    logic [7:0]  st_after;

    chip8_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
    );
    chip8_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_screen (
        .clk(clk), .we(scr_we), .addr(scr_addr), .wdata(scr_wdata), .rdata(scr_rdata)
    );
    chip8_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
        .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
    );

    assign op_x   = word_reg[11:8];
    assign op_y   = word_reg[7:4];
    assign op_n   = word_reg[3:0];
    assign op_kk  = word_reg[7:0];
    assign op_nnn = word_reg[11:0];

    // shared index adder for every access through I
    assign i_addr = i_reg[MEM_AW-1:0] + MEM_AW'(idx_reg);

    assign draw_line = vy_reg[4:0] + 5'(idx_reg);
    assign draw_col  = vx_reg[5:0] + 6'(col_reg);
    assign font_off  = cnt_reg - FONT_LO;
    assign bcd       = bcd_digits(vx_reg);
    assign released  = prev_reg & ~req_reg.keys_down;
    assign st_after  = (tick_reg && st_reg != 8'd0) ? st_reg - 8'd1 : st_reg;

    always_comb
    begin
        key_found = 1'b0;
        key_num   = 4'd0;
        for (int k = 15; k >= 0; k--)
        begin
            if (released[k])
            begin
                key_found = 1'b1;
                key_num   = 4'(k);
            end
        end
    end

    always_comb
    begin
        sum9        = {1'b0, vx_reg} + {1'b0, vy_reg};
        alu_r       = vy_reg;
        alu_f       = 1'b0;
        alu_flagged = 1'b0;
        alu_ok      = 1'b1;
        case (op_n)
            ALU_MOV: alu_r = vy_reg;
            ALU_OR:  alu_r = vx_reg | vy_reg;
            ALU_AND: alu_r = vx_reg & vy_reg;
            ALU_XOR: alu_r = vx_reg ^ vy_reg;
            ALU_ADD:
            begin
                alu_r = sum9[7:0];
                alu_f = sum9[8];
                alu_flagged = 1'b1;
            end
            ALU_SUB:
            begin
                alu_r = vx_reg - vy_reg;
                alu_f = vx_reg > vy_reg;
                alu_flagged = 1'b1;
            end
            ALU_SHR:
            begin
                alu_r = {1'b0, vx_reg[7:1]};
                alu_f = vx_reg[0];
                alu_flagged = 1'b1;
            end
            ALU_SBN:
            begin
                alu_r = vy_reg - vx_reg;
                alu_f = vy_reg > vx_reg;
                alu_flagged = 1'b1;
            end
            ALU_SHL:
            begin
                alu_r = {vx_reg[6:0], 1'b0};
                alu_f = vx_reg[7];
                alu_flagged = 1'b1;
            end
            default: alu_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        i_next      = i_reg;
        sp_next     = sp_reg;
        dt_next     = dt_reg;
        st_next     = st_reg;
        wait_next   = wait_reg;
        prev_next   = prev_reg;
        stack_we    = 1'b0;
        stack_idx   = sp_reg;
        req_next    = req_reg;
        hi_next     = hi_reg;
        word_next   = word_reg;
        npc_next    = npc_reg;
        err_next    = err_reg;
        pix_next    = pix_reg;
        drew_next   = drew_reg;
        tick_next   = tick_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        flag_next   = flag_reg;
        coll_next   = coll_reg;
        sprite_next = sprite_reg;
        idx_next    = idx_reg;
        col_next    = col_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_addr    = i_addr;
        mem_wdata   = 8'd0;
        scr_we      = 1'b0;
        scr_addr    = {draw_line, draw_col};
        scr_wdata   = 1'b0;
        v_we        = 1'b0;
        v_addr      = idx_reg;
        v_wdata     = 8'd0;
        pix_advance = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = cnt_reg;
                mem_wdata = (cnt_reg >= FONT_LO && cnt_reg < FONT_HI)
                            ? HEX_FONT[font_off[6:0]] : 8'd0;
                scr_we    = ~cnt_reg[MEM_AW-1];
                scr_addr  = cnt_reg[PIX_AW-1:0];
                v_we      = (cnt_reg < MEM_AW'(16));
                v_addr    = cnt_reg[3:0];
                cnt_next  = cnt_reg + 1'b1;
                if (&cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                mem_addr = pc_reg[MEM_AW-1:0];
                scr_addr = request.address[PIX_AW-1:0];
                if (start)
                begin
                    req_next  = request;
                    word_next = 16'd0;
                    npc_next  = pc_reg;
                    err_next  = ERR_NONE;
                    pix_next  = 1'b0;
                    drew_next = 1'b0;
                    tick_next = 1'b0;
                    state_next = S_END;
                    if (request.mode == MODE_LOAD)
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = request.address;
                        mem_wdata = request.load_byte;
                    end
                    else if (request.mode == MODE_PIXEL)
                    begin
                        state_next = S_PIX;
                    end
                    else if (request.mode == MODE_EXEC)
                    begin
                        if (pc_reg > 16'(MEMORY_BYTES - 2))
                        begin
                            err_next = ERR_PC_RANGE;
                        end
                        else
                        begin
                            state_next = S_FETCH1;
                        end
                    end
                end
            end
            S_PIX:
            begin
                pix_next   = scr_rdata & (req_reg.address < 12'(PIXELS));
                state_next = S_END;
            end
            S_FETCH1:
            begin
                hi_next    = mem_rdata;
                mem_addr   = pc_reg[MEM_AW-1:0] + 1'b1;
                state_next = S_FETCH2;
            end
            S_FETCH2:
            begin
                word_next  = {hi_reg, mem_rdata};
                pc_next    = pc_reg + 16'd2;
                npc_next   = pc_reg + 16'd2;
                v_addr     = hi_reg[3:0];
                state_next = S_RDX;
            end
            S_RDX:
            begin
                vx_next    = v_rdata;
                v_addr     = op_y;
                state_next = S_RDY;
            end
            S_RDY:
            begin
                vy_next    = v_rdata;
                v_addr     = 4'd0;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_END;
                tick_next  = (word_reg != 16'd0);
                idx_next   = 4'd0;
                col_next   = 3'd0;
                cnt_next   = '0;
                coll_next  = 1'b0;
                v_addr     = op_x;
                if (word_reg != 16'd0)
                begin
                    case (word_reg[15:12])
                        OPC_SYS:
                        begin
                            if (word_reg == WORD_CLS)
                            begin
                                drew_next  = 1'b1;
                                state_next = S_CLS;
                            end
                            else if (word_reg == WORD_RET)
                            begin
                                pc_next = stack_reg[sp_reg];
                                sp_next = sp_reg - 1'b1;
                            end
                        end
                        OPC_JP:   pc_next = {4'd0, op_nnn};
                        OPC_CALL:
                        begin
                            sp_next   = sp_reg + 1'b1;
                            stack_we  = 1'b1;
                            stack_idx = sp_reg + 1'b1;
                            pc_next   = {4'd0, op_nnn};
                        end
                        OPC_SEI:
                        begin
                            if (vx_reg == op_kk)
                            begin
                                pc_next = pc_reg + 16'd2;
                            end
                        end
                        OPC_SNEI:
                        begin
                            if (vx_reg != op_kk)
                            begin
                                pc_next = pc_reg + 16'd2;
                            end
                        end
                        OPC_SER, OPC_SNER:
                        begin
                            if (op_n != 4'd0)
                            begin
                                err_next  = ERR_UNDEFINED;
                                tick_next = 1'b0;
                            end
                            else if ((vx_reg == vy_reg) == (word_reg[15:12] == OPC_SER))
                            begin
                                pc_next = pc_reg + 16'd2;
                            end
                        end
                        OPC_LDI:
                        begin
                            v_we    = 1'b1;
                            v_wdata = op_kk;
                        end
                        OPC_ADDI:
                        begin
                            v_we    = 1'b1;
                            v_wdata = vx_reg + op_kk;
                        end
                        OPC_ALU:
                        begin
                            if (alu_ok)
                            begin
                                v_we      = 1'b1;
                                v_wdata   = alu_r;
                                flag_next = alu_f;
                                if (alu_flagged)
                                begin
                                    state_next = S_WVF;
                                end
                            end
                            else
                            begin
                                err_next  = ERR_UNDEFINED;
                                tick_next = 1'b0;
                            end
                        end
                        OPC_SETI: i_next = {4'd0, op_nnn};
                        OPC_JPV0: pc_next = {4'd0, op_nnn} + {8'd0, v_rdata};
                        OPC_RND:
                        begin
                            v_we    = 1'b1;
                            v_wdata = req_reg.random_byte & op_kk;
                        end
                        OPC_DRW:
                        begin
                            drew_next  = 1'b1;
                            state_next = (op_n == 4'd0) ? S_DFLAG : S_DROW;
                        end
                        OPC_KEY:
                        begin
                            if (op_kk == KK_SKP)
                            begin
                                if (req_reg.keys_down[op_x])
                                begin
                                    pc_next = pc_reg + 16'd2;
                                end
                            end
                            else if (op_kk == KK_SKNP)
                            begin
                                if (!req_reg.keys_down[op_x])
                                begin
                                    pc_next = pc_reg + 16'd2;
                                end
                            end
                            else
                            begin
                                err_next  = ERR_UNDEFINED;
                                tick_next = 1'b0;
                            end
                        end
                        OPC_MISC:
                        begin
                            case (op_kk)
                                KK_GETDT:
                                begin
                                    v_we    = 1'b1;
                                    v_wdata = dt_reg;
                                end
                                KK_WAITK:
                                begin
                                    prev_next = req_reg.keys_down;
                                    if (wait_reg && key_found)
                                    begin
                                        v_we      = 1'b1;
                                        v_wdata   = {4'd0, key_num};
                                        wait_next = 1'b0;
                                    end
                                    else
                                    begin
                                        wait_next = 1'b1;
                                        pc_next   = pc_reg - 16'd2;
                                    end
                                end
                                KK_SETDT: dt_next = vx_reg;
                                KK_SETST: st_next = vx_reg;
                                KK_ADDI:  i_next = i_reg + {8'd0, vx_reg};
                                KK_FONT:
                                begin
                                    i_next = 16'(FONT_BASE) + {6'd0, vx_reg, 2'b00}
                                             + {8'd0, vx_reg};
                                end
                                KK_BCD:   state_next = S_BCD;
                                KK_STORE: state_next = S_STR_RD;
                                KK_LOAD:  state_next = S_LD_RD;
                                default:
                                begin
                                    err_next  = ERR_UNDEFINED;
                                    tick_next = 1'b0;
                                end
                            endcase
                        end
                        default:
                        begin
                            err_next  = ERR_UNDEFINED;
                            tick_next = 1'b0;
                        end
                    endcase
                end
            end
            S_WVF:
            begin
                v_we       = 1'b1;
                v_addr     = 4'hF;
                v_wdata    = {7'd0, flag_reg};
                state_next = S_END;
            end
            S_CLS:
            begin
                scr_we   = 1'b1;
                scr_addr = cnt_reg[PIX_AW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (&cnt_reg[PIX_AW-1:0])
                begin
                    state_next = S_END;
                end
            end
            S_DROW:
            begin
                state_next = S_DBYTE;
            end
            S_DBYTE:
            begin
                sprite_next = mem_rdata;
                col_next    = 3'd0;
                state_next  = S_DPIX;
            end
            S_DPIX:
            begin
                if (sprite_reg[~col_reg])
                begin
                    state_next = S_DRMW;
                end
                else
                begin
                    pix_advance = 1'b1;
                end
            end
            S_DRMW:
            begin
                if (scr_rdata)
                begin
                    coll_next = 1'b1;
                end
                scr_we      = 1'b1;
                scr_wdata   = ~scr_rdata;
                pix_advance = 1'b1;
            end
            S_DFLAG:
            begin
                v_we       = 1'b1;
                v_addr     = 4'hF;
                v_wdata    = {7'd0, coll_reg};
                state_next = S_END;
            end
            S_BCD:
            begin
                mem_we = 1'b1;
                case (idx_reg[1:0])
                    2'd0:    mem_wdata = {4'd0, bcd[11:8]};
                    2'd1:    mem_wdata = {4'd0, bcd[7:4]};
                    default: mem_wdata = {4'd0, bcd[3:0]};
                endcase
                idx_next = idx_reg + 1'b1;
                if (idx_reg == 4'd2)
                begin
                    state_next = S_END;
                end
            end
            S_STR_RD:
            begin
                state_next = S_STR_WR;
            end
            S_STR_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = v_rdata;
                idx_next  = idx_reg + 1'b1;
                state_next = (idx_reg == op_x) ? S_END : S_STR_RD;
            end
            S_LD_RD:
            begin
                state_next = S_LD_WR;
            end
            S_LD_WR:
            begin
                v_we      = 1'b1;
                v_wdata   = mem_rdata;
                idx_next  = idx_reg + 1'b1;
                state_next = (idx_reg == op_x) ? S_END : S_LD_RD;
            end
            S_END:
            begin
                if (tick_reg && dt_reg != 8'd0)
                begin
                    dt_next = dt_reg - 8'd1;
                end
                st_next   = st_after;
                done_next = 1'b1;
                result_next.fetched_instruction = word_reg;
                result_next.next_pc             = npc_reg;
                result_next.error_code          = err_reg;
                result_next.pixel_value         = pix_reg;
                result_next.display_changed     = drew_reg;
                result_next.sound_active        = (st_after != 8'd0);
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        if (pix_advance)
        begin
            if (col_reg == 3'd7)
            begin
                col_next = 3'd0;
                if (idx_reg == op_n - 4'd1)
                begin
                    state_next = S_DFLAG;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DROW;
                end
            end
            else
            begin
                col_next   = col_reg + 1'b1;
                state_next = S_DPIX;
            end
        end

        if (cfg_we)
        begin
            pc_next = {4'd0, cfg_data};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pc_reg    <= RESET_PC;
            i_reg     <= '0;
            sp_reg    <= '0;
            dt_reg    <= '0;
            st_reg    <= '0;
            wait_reg  <= 1'b0;
            prev_reg  <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            for (int k = 0; k < STACK_DEPTH; k++)
            begin
                stack_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            i_reg     <= i_next;
            sp_reg    <= sp_next;
            dt_reg    <= dt_next;
            st_reg    <= st_next;
            wait_reg  <= wait_next;
            prev_reg  <= prev_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (stack_we)
            begin
                stack_reg[stack_idx] <= pc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        hi_reg     <= hi_next;
        word_reg   <= word_next;
        npc_reg    <= npc_next;
        err_reg    <= err_next;
        pix_reg    <= pix_next;
        drew_reg   <= drew_next;
        tick_reg   <= tick_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        flag_reg   <= flag_next;
        coll_reg   <= coll_next;
        sprite_reg <= sprite_next;
        idx_reg    <= idx_next;
        col_reg    <= col_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_sound_match: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.sound_active == (st_reg != 8'd0)))
        else $error("sound flag disagrees with sound timer");

endmodule
`default_nettype wire

// ===== src/chip8_ram.sv =====
// chip8_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none
module chip8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end
endmodule
`default_nettype wire
